// ----- rtl/csrmac_pkg.sv -----
// shared types and constants for the csr sparse matrix-vector multiply-accumulate
`timescale 1ns / 1ps

package csrmac_pkg;

	// field widths
	localparam int OP_W    = 2;
	localparam int INDEX_W = 10;
	localparam int DATA_W  = 32;
	localparam int SUM_W   = 64;
	localparam int ROW_W   = 16;

	// item opcodes
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_NONZERO = 2'd1;
	localparam logic [OP_W-1:0] OP_EMPTY   = 2'd2;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// saturation rails for the q16.48 row sum
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// one multiply-accumulate job handed from front to back
	typedef struct packed {
		logic signed [DATA_W-1:0] mat;
		logic signed [DATA_W-1:0] vec;
		logic                     flush;
	} mac_item_t;

endpackage

// ----- rtl/csrmac_front.sv -----
// front end: takes input transactions, owns the vector store, builds mac jobs
`timescale 1ns / 1ps

module csrmac_front
	import csrmac_pkg::*;
#(
	parameter int VECTOR_LEN = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          op,
	input  logic [INDEX_W-1:0]       index,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     row_end,
	output logic                     job_valid,
	input  logic                     job_ready,
	output mac_item_t                job
);

	localparam int          AW   = $clog2(VECTOR_LEN);
	localparam logic [31:0] VLEN = VECTOR_LEN;

	logic signed [DATA_W-1:0] mem [VECTOR_LEN];

	logic          accept;
	logic          in_range;
	logic [AW-1:0] addr;
	logic          do_load;
	logic          do_read;
	logic          take_s1;
	logic          flush_in;

	logic                     valid_s1;
	logic signed [DATA_W-1:0] mat_s1;
	logic signed [DATA_W-1:0] vec_s1;
	logic                     zero_s1;
	logic                     flush_s1;

	// accept whenever stage one is empty or moving into the queue
	assign in_ready = !valid_s1 || job_ready;
	assign accept   = in_valid && in_ready;
	assign in_range = 32'(index) < VLEN;
	assign addr     = AW'(index);

	// classify the incoming transaction
	always_comb begin
		do_load  = 1'b0;
		take_s1  = 1'b0;
		flush_in = 1'b0;
		unique case (op)
			OP_LOAD: begin
				do_load = in_range;
			end
			OP_NONZERO: begin
				take_s1  = 1'b1;
				flush_in = row_end;
			end
			OP_EMPTY: begin
				take_s1  = 1'b1;
				flush_in = 1'b1;
			end
			default: begin
				take_s1 = 1'b0;
			end
		endcase
	end

	assign do_read = accept && take_s1 && (op == OP_NONZERO);

	// vector store, written by loads and read by nonzeros
	always_ff @(posedge clk) begin
		if (accept && do_load) begin
			mem[addr] <= value;
		end
		if (do_read) begin
			vec_s1 <= mem[addr];
		end
	end

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && take_s1;
		end
	end

	// stage one payload; an empty row or out-of-range column contributes zero
	always_ff @(posedge clk) begin
		if (accept && take_s1) begin
			mat_s1   <= value;
			zero_s1  <= (op == OP_EMPTY) || !in_range;
			flush_s1 <= flush_in;
		end
	end

	assign job_valid = valid_s1;
	assign job.mat   = mat_s1;
	assign job.vec   = zero_s1 ? '0 : vec_s1;
	assign job.flush = flush_s1;

endmodule

// ----- rtl/csrmac_queue.sv -----
// small fifo of mac jobs between front and back
`timescale 1ns / 1ps

module csrmac_queue
	import csrmac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  mac_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output mac_item_t pop_item
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_SLOT  = PW'(QUEUE_DEPTH - 1);

	mac_item_t     slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = count_q != FULL_COUNT;
	assign pop_valid  = count_q != '0;
	assign pop_item   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/csrmac_back.sv -----
// back end: multiply, saturating row accumulate, result register
`timescale 1ns / 1ps

module csrmac_back
	import csrmac_pkg::*;
#(
	parameter int MAX_ROWS = 65536
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_valid,
	output logic                    job_ready,
	input  mac_item_t               job,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ROW_W-1:0]        row_number,
	output logic signed [SUM_W-1:0] row_sum,
	output logic                    saturated
);

	localparam int            RW       = $clog2(MAX_ROWS);
	localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

	logic signed [SUM_W-1:0] prod;
	logic                    acc_go;

	logic                    valid_s2;
	logic signed [SUM_W-1:0] prod_s2;
	logic                    flush_s2;

	logic signed [SUM_W-1:0] acc_q;
	logic                    clip_q;
	logic [RW-1:0]           row_cnt_q;
	logic                    out_valid_q;
	logic [ROW_W-1:0]        row_number_q;
	logic signed [SUM_W-1:0] row_sum_q;
	logic                    saturated_q;

	logic signed [SUM_W:0]   sum_wide;
	logic                    ovf;
	logic signed [SUM_W-1:0] sat_sum;

	// exact q16.48 product
	assign prod = SUM_W'(job.mat) * SUM_W'(job.vec);

	// accumulate unless a row result would land on a full output register
	assign acc_go    = valid_s2 && (!flush_s2 || !out_valid_q || out_ready);
	assign job_ready = !valid_s2 || acc_go;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (job_ready) begin
			valid_s2 <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			prod_s2  <= prod;
			flush_s2 <= job.flush;
		end
	end

	// saturating add
	assign sum_wide = {acc_q[SUM_W-1], acc_q} + {prod_s2[SUM_W-1], prod_s2};
	assign ovf      = sum_wide[SUM_W] ^ sum_wide[SUM_W-1];
	assign sat_sum  = ovf ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX) : sum_wide[SUM_W-1:0];

	// row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			clip_q    <= 1'b0;
			row_cnt_q <= '0;
		end else if (acc_go) begin
			if (flush_s2) begin
				acc_q     <= '0;
				clip_q    <= 1'b0;
				row_cnt_q <= (row_cnt_q == ROW_LAST) ? '0 : row_cnt_q + 1'b1;
			end else begin
				acc_q  <= sat_sum;
				clip_q <= clip_q | ovf;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_go && flush_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (acc_go && flush_s2) begin
			row_number_q <= ROW_W'(row_cnt_q);
			row_sum_q    <= sat_sum;
			saturated_q  <= clip_q | ovf;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_number = row_number_q;
	assign row_sum    = row_sum_q;
	assign saturated  = saturated_q;

endmodule

// ----- rtl/csr_sparse_matrix_vector_mac.sv -----
// top level of the csr sparse matrix times dense vector multiply-accumulate
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_ready  | op, index, value, row_end
//   out     | output    | out_valid / out_ready| row_number, row_sum, saturated
//
// one input transaction per cycle while in_ready is high; loads write the vector store at acceptance
// a row result passes, once its row-end or empty-row transaction is accepted (store read
// at acceptance), through the stage one register, queue, multiplier register and result register
// a four-entry queue decouples the front from the back; input stalls only when the
// queue is full because the result register is held by out_ready
// reset clears control, row sum, clip flag and row counter; the vector store is not cleared
`timescale 1ns / 1ps

module csr_sparse_matrix_vector_mac
	import csrmac_pkg::*;
#(
	parameter int VECTOR_LEN = 1024,
	parameter int MAX_ROWS   = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          op,
	input  logic [INDEX_W-1:0]       index,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     row_end,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ROW_W-1:0]         row_number,
	output logic signed [SUM_W-1:0]  row_sum,
	output logic                     saturated
);

	logic      fq_valid;
	logic      fq_ready;
	mac_item_t fq_item;
	logic      qb_valid;
	logic      qb_ready;
	mac_item_t qb_item;

	// classification and vector store
	csrmac_front #(
		.VECTOR_LEN(VECTOR_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.index    (index),
		.value    (value),
		.row_end  (row_end),
		.job_valid(fq_valid),
		.job_ready(fq_ready),
		.job      (fq_item)
	);

	// job queue
	csrmac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_item (fq_item),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_item  (qb_item)
	);

	// multiply-accumulate and result
	csrmac_back #(
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_number(row_number),
		.row_sum   (row_sum),
		.saturated (saturated)
	);

endmodule

// ----- rtl/csrmac_checker.sv -----
// port-level checker for the csr multiply-accumulate block, bound to the top level
`timescale 1ns / 1ps

module csrmac_checker
	import csrmac_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic [OP_W-1:0]          op,
	input logic [INDEX_W-1:0]       index,
	input logic signed [DATA_W-1:0] value,
	input logic                     row_end,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [ROW_W-1:0]         row_number,
	input logic signed [SUM_W-1:0]  row_sum,
	input logic                     saturated
);

	// reset leaves the input open and no result pending
	a_reset_state: assert property (@(posedge clk)
		!arst_n |-> in_ready && !out_valid)
		else $error("reset state wrong");

	// input backpressure only comes from a result held at the output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	// a stalled result transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_number)
			&& $stable(row_sum) && $stable(saturated))
		else $error("result changed while stalled");

endmodule

bind csr_sparse_matrix_vector_mac csrmac_checker u_checker (.*);
